// ----- hdl/hue_to_weighted_rgb_top_macros.svh -----
// Assertion macros for the hue to RGB top design file.
`ifndef HUE_TO_WEIGHTED_RGB_TOP_MACROS_SVH
`define HUE_TO_WEIGHTED_RGB_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked only while out of reset.
`define HWR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define HWR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define HWR_ASSERT(lbl, prop, msg)

`define HWR_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ----- hdl/hwr_pkg.sv -----
// Constants and types for the hue to weighted RGB converter.
package hwr_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned HueMul  = 703;
  localparam int unsigned HueDen  = 30000;
  localparam int unsigned PosW    = 18;   // hue * 703 < 2^18
  localparam int unsigned NumW    = 15;   // numerator up to 30000
  localparam int unsigned ProdW   = ChanW + NumW;

  // floor(x / 30000) == (x * RecipMul) >> RecipShift for every x < 2^ProdW
  localparam int unsigned RecipShift = 38;
  localparam longint unsigned RecipMulL =
    ((64'd1 << RecipShift) + HueDen - 1) / HueDen;
  localparam int unsigned RecipW = 24;
  localparam logic [RecipW-1:0] RecipMul = RecipMulL[RecipW-1:0];
  localparam int unsigned RecipProdW = ProdW + RecipW;

  // First hue code of each sector: ceil(k * 30000 / 703)
  localparam logic [ChanW-1:0] SecStart1 = ChanW'((1 * HueDen + HueMul - 1) / HueMul);
  localparam logic [ChanW-1:0] SecStart2 = ChanW'((2 * HueDen + HueMul - 1) / HueMul);
  localparam logic [ChanW-1:0] SecStart3 = ChanW'((3 * HueDen + HueMul - 1) / HueMul);
  localparam logic [ChanW-1:0] SecStart4 = ChanW'((4 * HueDen + HueMul - 1) / HueMul);
  localparam logic [ChanW-1:0] SecStart5 = ChanW'((5 * HueDen + HueMul - 1) / HueMul);

  // Sector base positions: k * 30000
  localparam logic [PosW-1:0] SecBase1 = PosW'(1 * HueDen);
  localparam logic [PosW-1:0] SecBase2 = PosW'(2 * HueDen);
  localparam logic [PosW-1:0] SecBase3 = PosW'(3 * HueDen);
  localparam logic [PosW-1:0] SecBase4 = PosW'(4 * HueDen);
  localparam logic [PosW-1:0] SecBase5 = PosW'(5 * HueDen);

  // Sector: first letter carries the amount, second letter the ramp
  typedef enum logic [2:0] {
    SecRG = 3'd0,
    SecGR = 3'd1,
    SecGB = 3'd2,
    SecBG = 3'd3,
    SecBR = 3'd4,
    SecRB = 3'd5
  } sector_e;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [NumW-1:0]  num_t;
  typedef logic [ProdW-1:0] prod_t;

endpackage

// ----- hdl/hue_to_weighted_rgb_top.sv -----
// Hue and amount to full-saturation RGB converter, four-stage pipeline.
//
//  channel  | dir | fields (lsb first)            | width
//  ---------+-----+-------------------------------+------
//  s_axis   | in  | hue[7:0], amount[15:8]        | 16
//  m_axis   | out | red[7:0], green[15:8],        | 24
//           |     | blue[23:16]                   |
//
// One transaction per clock sustained while the output is not stalled. A result
// passes through the input reg, sector/numerator, amount * numerator,
// reciprocal divide and channel select into the result register.
// Each stage advances when the stage after it is empty or moving, so
// bubbles are squeezed out during an output stall and the input keeps
// taking transactions until the pipe is full.
// Async active-low reset clears the valid flags only.

`include "hue_to_weighted_rgb_top_macros.svh"

module hue_to_weighted_rgb_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // hue[7:0], amount[15:8]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o    // red[7:0], green[15:8], blue[23:16]
);

  // ---- stage handshake ----
  logic v0_q, v1_q, v2_q, v3_q;
  logic adv0, adv1, adv2, adv3;

  assign adv3 = !v3_q || m_axis_tready_i;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign adv0 = !v0_q || adv1;

  assign s_axis_tready_o = adv0;
  assign m_axis_tvalid_o = v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv0) v0_q <= s_axis_tvalid_i;
      if (adv1) v1_q <= v0_q;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  // ---- stage 0: input register ----
  hwr_pkg::chan_t hue_q0, amount_q0;

  always_ff @(posedge clk_i) begin
    if (adv0 && s_axis_tvalid_i) begin
      hue_q0    <= s_axis_tdata_i[7:0];
      amount_q0 <= s_axis_tdata_i[15:8];
    end
  end

  // ---- stage 1: sector and ramp numerator ----
  // Sector found by comparing the hue code with the sector start codes;
  // remainder is hue*703 less the sector base.
  hwr_pkg::sector_e           sector_d1;
  logic [hwr_pkg::PosW-1:0]   pos_d1;
  logic [hwr_pkg::PosW-1:0]   base_d1;
  logic [hwr_pkg::PosW-1:0]   rem_full_d1;
  hwr_pkg::num_t              rem_d1;
  hwr_pkg::num_t              num_d1;
  logic                       falling_d1;

  always_comb begin
    if (hue_q0 >= hwr_pkg::SecStart5)      sector_d1 = hwr_pkg::SecRB;
    else if (hue_q0 >= hwr_pkg::SecStart4) sector_d1 = hwr_pkg::SecBR;
    else if (hue_q0 >= hwr_pkg::SecStart3) sector_d1 = hwr_pkg::SecBG;
    else if (hue_q0 >= hwr_pkg::SecStart2) sector_d1 = hwr_pkg::SecGB;
    else if (hue_q0 >= hwr_pkg::SecStart1) sector_d1 = hwr_pkg::SecGR;
    else                                   sector_d1 = hwr_pkg::SecRG;

    pos_d1 = hwr_pkg::PosW'(hue_q0) * hwr_pkg::PosW'(hwr_pkg::HueMul);

    case (sector_d1)
      hwr_pkg::SecRG: base_d1 = '0;
      hwr_pkg::SecGR: base_d1 = hwr_pkg::SecBase1;
      hwr_pkg::SecGB: base_d1 = hwr_pkg::SecBase2;
      hwr_pkg::SecBG: base_d1 = hwr_pkg::SecBase3;
      hwr_pkg::SecBR: base_d1 = hwr_pkg::SecBase4;
      default:        base_d1 = hwr_pkg::SecBase5;
    endcase

    rem_full_d1 = pos_d1 - base_d1;
    rem_d1      = rem_full_d1[hwr_pkg::NumW-1:0];

    // odd sectors ramp down: numerator is 30000 - rem
    falling_d1 = sector_d1 inside {hwr_pkg::SecGR, hwr_pkg::SecBG, hwr_pkg::SecRB};
    num_d1 = falling_d1 ? (hwr_pkg::NumW'(hwr_pkg::HueDen) - rem_d1) : rem_d1;
  end

  hwr_pkg::sector_e sector_q1;
  hwr_pkg::num_t    num_q1;
  hwr_pkg::chan_t   amount_q1;

  always_ff @(posedge clk_i) begin
    if (adv1 && v0_q) begin
      sector_q1 <= sector_d1;
      num_q1    <= num_d1;
      amount_q1 <= amount_q0;
    end
  end

  // ---- stage 2: amount * numerator ----
  hwr_pkg::prod_t   prod_d2;
  hwr_pkg::prod_t   prod_q2;
  hwr_pkg::sector_e sector_q2;
  hwr_pkg::chan_t   amount_q2;

  assign prod_d2 = hwr_pkg::ProdW'(amount_q1) * hwr_pkg::ProdW'(num_q1);

  always_ff @(posedge clk_i) begin
    if (adv2 && v1_q) begin
      prod_q2   <= prod_d2;
      sector_q2 <= sector_q1;
      amount_q2 <= amount_q1;
    end
  end

  // ---- stage 3: divide by 30000 and route channels ----
  // Reciprocal multiply is exact over the whole product range.
  logic [hwr_pkg::RecipProdW-1:0] recip_d3;
  hwr_pkg::chan_t                 ramp_d3;
  hwr_pkg::chan_t                 red_d3, green_d3, blue_d3;

  always_comb begin
    recip_d3 = hwr_pkg::RecipProdW'(prod_q2) * hwr_pkg::RecipProdW'(hwr_pkg::RecipMul);
    ramp_d3  = recip_d3[hwr_pkg::RecipShift +: hwr_pkg::ChanW];

    case (sector_q2)
      hwr_pkg::SecRG: begin
        red_d3 = amount_q2; green_d3 = ramp_d3;   blue_d3 = '0;
      end
      hwr_pkg::SecGR: begin
        red_d3 = ramp_d3;   green_d3 = amount_q2; blue_d3 = '0;
      end
      hwr_pkg::SecGB: begin
        red_d3 = '0;        green_d3 = amount_q2; blue_d3 = ramp_d3;
      end
      hwr_pkg::SecBG: begin
        red_d3 = '0;        green_d3 = ramp_d3;   blue_d3 = amount_q2;
      end
      hwr_pkg::SecBR: begin
        red_d3 = ramp_d3;   green_d3 = '0;        blue_d3 = amount_q2;
      end
      default: begin
        red_d3 = amount_q2; green_d3 = '0;        blue_d3 = ramp_d3;
      end
    endcase
  end

  hwr_pkg::chan_t red_q3, green_q3, blue_q3;

  always_ff @(posedge clk_i) begin
    if (adv3 && v2_q) begin
      red_q3   <= red_d3;
      green_q3 <= green_d3;
      blue_q3  <= blue_d3;
    end
  end

  assign m_axis_tdata_o = {blue_q3, green_q3, red_q3};

  // ---- assertions ----
  `HWR_ASSERT(a_num_range, v1_q |-> (num_q1 <= hwr_pkg::NumW'(hwr_pkg::HueDen)),
              "ramp numerator above denominator")
  `HWR_ASSERT(a_ramp_le_amount, v2_q |-> (ramp_d3 <= amount_q2),
              "ramp exceeds amount")
  `HWR_ASSERT(a_one_zero_chan,
              m_axis_tvalid_o |-> (red_q3 == '0 || green_q3 == '0 || blue_q3 == '0),
              "result has no zero channel")
  `HWR_ASSERT(a_ready_when_out_empty, !v3_q |-> s_axis_tready_o,
              "input stalled with empty output stage")
  // valid flags are only known once the first edge under reset has passed
  `HWR_ASSERT_ALWAYS(a_reset_no_valid, !rst_ni |=> !m_axis_tvalid_o,
                     "output valid during reset")

endmodule

// ----- bench/hwr_checker.sv -----
// Colour scoreboard for the hue to weighted RGB converter.
`timescale 1ns / 1ps

module hwr_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [15:0] s_tdata_i,   // hue[7:0], amount[15:8]
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [23:0] m_tdata_i,   // red[7:0], green[15:8], blue[23:16]
  output int unsigned errors_o,
  output int unsigned colours_o,
  output int unsigned pending_o,
  output logic [5:0]  sectors_o
);

  // packed so that red lands in the low byte, as on m_axis
  typedef struct packed {
    hwr_pkg::chan_t blue;
    hwr_pkg::chan_t green;
    hwr_pkg::chan_t red;
  } rgb_t;

  localparam int unsigned MaxPrinted = 30;

  rgb_t colour_q[$];

  // exact rational hue position: whole part is the sector, remainder the fraction
  function automatic rgb_t weigh_colour(hwr_pkg::chan_t hue, hwr_pkg::chan_t amount);
    int unsigned    pos, whole, rem, num, ramp;
    hwr_pkg::chan_t r8;
    rgb_t           c;
    pos   = hue * hwr_pkg::HueMul;
    whole = pos / hwr_pkg::HueDen;
    rem   = pos % hwr_pkg::HueDen;
    num   = whole[0] ? hwr_pkg::HueDen - rem : rem;   // falling ramp in odd sectors
    ramp  = (amount * num) / hwr_pkg::HueDen;
    r8    = hwr_pkg::chan_t'(ramp);
    case (hwr_pkg::sector_e'(whole[2:0]))
      hwr_pkg::SecRG: c = '{red: amount, green: r8,     blue: '0};
      hwr_pkg::SecGR: c = '{red: r8,     green: amount, blue: '0};
      hwr_pkg::SecGB: c = '{red: '0,     green: amount, blue: r8};
      hwr_pkg::SecBG: c = '{red: '0,     green: r8,     blue: amount};
      hwr_pkg::SecBR: c = '{red: r8,     green: '0,     blue: amount};
      default:        c = '{red: amount, green: '0,     blue: r8};
    endcase
    return c;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    if (errors_o < MaxPrinted)
      $display("%0t: colour %0d %s: expected %0d, got %0d",
               $realtime, colours_o, what, want, got);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rgb_t        got;
    rgb_t        want;
    int unsigned sec;
    if (!rst_ni) begin
      colour_q.delete();
      errors_o  = 0;
      colours_o = 0;
      pending_o = 0;
      sectors_o = '0;
    end else begin
      // result side first: it can only belong to an older transaction
      if (m_tvalid_i && m_tready_i) begin
        got = rgb_t'(m_tdata_i);
        if (colour_q.size() == 0) begin
          report_mismatch("arrived with nothing pending", 0, 32'(m_tdata_i));
        end else begin
          want = colour_q.pop_front();
          if (got.red != want.red)
            report_mismatch("red", 32'(want.red), 32'(got.red));
          if (got.green != want.green)
            report_mismatch("green", 32'(want.green), 32'(got.green));
          if (got.blue != want.blue)
            report_mismatch("blue", 32'(want.blue), 32'(got.blue));
        end
        colours_o++;
      end
      if (s_tvalid_i && s_tready_i) begin
        colour_q.push_back(weigh_colour(s_tdata_i[7:0], s_tdata_i[15:8]));
        sec = (s_tdata_i[7:0] * hwr_pkg::HueMul) / hwr_pkg::HueDen;
        sectors_o[sec] = 1'b1;
      end
      pending_o = $unsigned(colour_q.size());
    end
  end

endmodule

// ----- bench/tb_hue_to_weighted_rgb_top.sv -----
// Stimulus and verdict for the hue to weighted RGB converter.
`timescale 1ns / 1ps

module tb_hue_to_weighted_rgb_top;

  // slowest phases: 86% idle or stall on one side; the limit sits well
  // above the length of the whole run
  localparam int unsigned CycleLimit     = 400_000;
  localparam int unsigned TailCycles     = 20;    // pipe is four deep
  localparam int unsigned RandomPerPhase = 490;
  localparam int unsigned NumPhases      = 4;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;   // hue[7:0], amount[15:8]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;         // red[7:0], green[15:8], blue[23:16]

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned pixels = 0;
  int unsigned cycles = 0;

  int unsigned errors;
  int unsigned colours;
  int unsigned pending;
  logic [5:0]  sectors;

  // idle percentages per phase: none, sparse sender, stalling receiver, both
  int unsigned phase_idle  [NumPhases] = '{0, 86, 0, 17};
  int unsigned phase_stall [NumPhases] = '{0, 0, 86, 17};

  // hues either side of every sector edge, plus the ends of the range
  hwr_pkg::chan_t edge_hues [12] = '{8'd0, 8'd42, 8'd43, 8'd85, 8'd86, 8'd128,
                                     8'd129, 8'd170, 8'd171, 8'd213, 8'd214, 8'd255};

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  hue_to_weighted_rgb_top u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  hwr_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .s_tvalid_i (s_tvalid),
    .s_tready_i (s_tready),
    .s_tdata_i  (s_tdata),
    .m_tvalid_i (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_i  (m_tdata),
    .errors_o   (errors),
    .colours_o  (colours),
    .pending_o  (pending),
    .sectors_o  (sectors)
  );

  // receiver back-pressure, redrawn every falling edge
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d colours still pending", cycles, pending);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Called at a falling edge. Idle cycles put junk on tdata with tvalid low,
  // then the pixel is held until the transaction completes. Returns at the
  // falling edge after acceptance, so tvalid gets one assignment per edge.
  task automatic send_pixel(input hwr_pkg::chan_t hue, input hwr_pkg::chan_t amount);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 16'($urandom);
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {amount, hue};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pixels++;
    @(negedge clk);
  endtask

  // sender goes quiet until every colour has come back
  task automatic drain_pipe();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // mostly uniform; some hues on sector edges, some amounts at the extremes
  task automatic send_random_pixel();
    hwr_pkg::chan_t hue;
    hwr_pkg::chan_t amount;
    hue = ($urandom_range(0, 7) == 0) ? edge_hues[$urandom_range(0, 11)]
                                      : hwr_pkg::chan_t'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0:       amount = '0;
      1:       amount = '1;
      default: amount = hwr_pkg::chan_t'($urandom_range(0, 255));
    endcase
    send_pixel(hue, amount);
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: full brightness across every sector edge
    foreach (edge_hues[i]) send_pixel(edge_hues[i], 8'd255);
    // zero amount gives black whatever the hue
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd100, 8'd0);
    send_pixel(8'd255, 8'd0);
    // smallest non-zero amount, ramp floors to zero
    send_pixel(8'd42, 8'd1);
    send_pixel(8'd43, 8'd1);
    // alternating bit patterns and other mixed values on both fields
    send_pixel(8'hAA, 8'h55);
    send_pixel(8'h55, 8'hAA);
    send_pixel(8'hFF, 8'h01);
    send_pixel(8'h01, 8'hFF);
    send_pixel(8'd64, 8'd128);
    send_pixel(8'd192, 8'd127);
    drain_pipe();

    for (int p = 0; p < NumPhases; p++) begin
      send_idle_pct  = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      repeat (RandomPerPhase) send_random_pixel();
      drain_pipe();
    end

    repeat (TailCycles) @(negedge clk);

    $display("Run covered %0d pixels in %0d cycles, %0d colours checked, %0d of 6 sectors",
             pixels, cycles, colours, $countones(sectors));
    $display("Idling phases: none, sparse input, stalled output, both sides mixed");
    if (errors == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d colours never arrived", errors, pending);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
